/* sv/tppf_pkg.sv */
// shared types and constants of the tcp payload pattern filter
package tppf_pkg;

  localparam logic [7:0]  ProtoReset   = 8'd6;
  localparam logic [15:0] PortReset    = 16'd8080;
  localparam logic [31:0] PatternReset = 32'h2E65_7865;
  localparam int unsigned NumCells     = 3;

  typedef enum logic [2:0] {
    REASON_PROTOCOL  = 3'd0,
    REASON_PORT      = 3'd1,
    REASON_FOUND     = 3'd2,
    REASON_CLEAN     = 3'd3,
    REASON_TRUNCATED = 3'd4
  } reason_e;

  typedef enum logic [1:0] {
    CFG_PROTOCOL = 2'd0,
    CFG_PORT     = 2'd1,
    CFG_PATTERN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic    scan_win;
    logic    hit;
    reason_e reason;
  } hdr_stat_t;

endpackage

/* sv/tppf_if.sv */
// channel interfaces of the tcp payload pattern filter
interface tppf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tppf_out_if;
  logic       valid;
  logic       ready;
  logic       drop;
  logic [2:0] reason;
  modport source (output valid, output drop, output reason, input ready);
  modport sink (input valid, input drop, input reason, output ready);
endinterface

interface tppf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/tcp_payload_pattern_filter.sv */
// top level of the tcp payload pattern filter
// latency: verdict valid the cycle after the last byte's transaction
// throughput: one byte per cycle while the result sink keeps up
// a stalled verdict holds further bytes until it is taken
// reset: registers back to protocol 6, port 8080, pattern ".exe"; packet state cleared
module tcp_payload_pattern_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  tppf_in_if.sink      in_i,
  tppf_out_if.source   out_o,
  tppf_cfg_if.sink     cfg_i
);
  import tppf_pkg::*;

  logic [7:0]  match_protocol_q;
  logic [15:0] match_port_q;
  logic [31:0] pattern_word_q;

  logic        in_acc;
  logic        pkt_end;
  hdr_stat_t   stat;
  logic        stop_q;
  logic        found_q, found_d;
  logic        shift;
  logic        match;

  logic [7:0]  cell_byte [NumCells+1];
  logic        cell_vld  [NumCells+1];
  logic [NumCells-1:0] cell_eq;

  logic        out_valid_q;
  logic        drop_q;
  reason_e     reason_q;
  reason_e     reason_n;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_protocol_q <= ProtoReset;
      match_port_q     <= PortReset;
      pattern_word_q   <= PatternReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PROTOCOL: match_protocol_q <= cfg_i.data[7:0];
        CFG_PORT:     match_port_q     <= cfg_i.data[15:0];
        CFG_PATTERN:  pattern_word_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign pkt_end    = in_acc && in_i.last_byte;

  tppf_hdr u_hdr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (in_acc),
    .data_byte_i      (in_i.data_byte),
    .last_byte_i      (in_i.last_byte),
    .match_protocol_i (match_protocol_q),
    .match_port_i     (match_port_q),
    .stat_o           (stat)
  );

  assign shift        = in_acc && stat.scan_win && !stop_q && (in_i.data_byte != 8'd0);
  assign cell_byte[0] = in_i.data_byte;
  assign cell_vld[0]  = 1'b1;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    tppf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (pkt_end),
      .shift_i    (shift),
      .byte_i     (cell_byte[k]),
      .vld_i      (cell_vld[k]),
      .pat_byte_i (pattern_word_q[8*(k+1) +: 8]),
      .byte_o     (cell_byte[k+1]),
      .vld_o      (cell_vld[k+1]),
      .eq_o       (cell_eq[k])
    );
  end

  assign match   = (&cell_eq) && (in_i.data_byte == pattern_word_q[7:0]);
  assign found_d = found_q || (shift && match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (pkt_end) begin
      stop_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (in_acc) begin
      found_q <= found_d;
      if (stat.scan_win && in_i.data_byte == 8'd0) stop_q <= 1'b1;
    end
  end

  always_comb begin
    reason_n = stat.reason;
    if (stat.hit) reason_n = found_d ? REASON_FOUND : REASON_CLEAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pkt_end) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_end) begin
      drop_q   <= (reason_n == REASON_FOUND);
      reason_q <= reason_n;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.drop   = drop_q;
  assign out_o.reason = reason_q;

  a_drop_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drop_q == (reason_q == REASON_FOUND)))
    else $error("drop disagrees with reason");

  a_verdict_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_end |=> out_valid_q)
    else $error("verdict missing after last byte");

  a_no_shift_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !shift)
    else $error("scan continued after zero byte");

  a_found_full_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> cell_vld[NumCells])
    else $error("match flagged with partial history");

endmodule

/* sv/tppf_hdr.sv */
// header field capture, payload window and verdict precheck
module tppf_hdr (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [7:0]        match_protocol_i,
  input  logic [15:0]       match_port_i,
  output tppf_pkg::hdr_stat_t stat_o
);
  import tppf_pkg::*;

  logic [15:0] idx_q;
  logic [5:0]  ihl_q, ihl_d;
  logic [5:0]  thb_q, thb_d;
  logic [15:0] len_q, len_d;
  logic [15:0] dport_q, dport_d;
  logic [7:0]  proto_q, proto_d;
  logic [16:0] idx_x;
  logic [16:0] ihl_x;
  logic [16:0] ihl_dx;
  logic [6:0]  start;
  logic        not_first;

  assign idx_x     = {1'b0, idx_q};
  assign ihl_x     = {11'd0, ihl_q};
  assign ihl_dx    = {11'd0, ihl_d};
  assign not_first = (idx_q != 16'd0);
  assign start     = {1'b0, ihl_q} + ((thb_q > 6'd13) ? {1'b0, thb_q} : 7'd13);

  always_comb begin
    ihl_d   = (idx_q == 16'd0) ? {data_byte_i[3:0], 2'b00} : ihl_q;
    len_d   = len_q;
    proto_d = (idx_q == 16'd9) ? data_byte_i : proto_q;
    dport_d = dport_q;
    thb_d   = thb_q;
    if (idx_q == 16'd2) len_d[15:8] = data_byte_i;
    if (idx_q == 16'd3) len_d[7:0]  = data_byte_i;
    if (not_first && idx_x == ihl_x + 17'd2)  dport_d[15:8] = data_byte_i;
    if (not_first && idx_x == ihl_x + 17'd3)  dport_d[7:0]  = data_byte_i;
    if (not_first && idx_x == ihl_x + 17'd12) thb_d = {data_byte_i[7:4], 2'b00};
  end

  always_comb begin
    stat_o.scan_win = not_first && (idx_q >= {9'd0, start}) && (idx_q < len_q);
    stat_o.hit      = 1'b0;
    stat_o.reason   = REASON_TRUNCATED;
    if (idx_q < 16'd9) begin
      stat_o.reason = REASON_TRUNCATED;
    end else if (proto_d != match_protocol_i) begin
      stat_o.reason = REASON_PROTOCOL;
    end else if (idx_x < ihl_dx + 17'd3) begin
      stat_o.reason = REASON_TRUNCATED;
    end else if (dport_d != match_port_i) begin
      stat_o.reason = REASON_PORT;
    end else if (idx_x < ihl_dx + 17'd12) begin
      stat_o.reason = REASON_TRUNCATED;
    end else begin
      stat_o.reason = REASON_CLEAN;
      stat_o.hit    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      ihl_q   <= '0;
      thb_q   <= '0;
      len_q   <= '0;
      dport_q <= '0;
      proto_q <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        idx_q   <= '0;
        ihl_q   <= '0;
        thb_q   <= '0;
        len_q   <= '0;
        dport_q <= '0;
        proto_q <= '0;
      end else begin
        if (idx_q != 16'hFFFF) idx_q <= idx_q + 16'd1;
        ihl_q   <= ihl_d;
        thb_q   <= thb_d;
        len_q   <= len_d;
        dport_q <= dport_d;
        proto_q <= proto_d;
      end
    end
  end

endmodule

/* sv/tppf_cell.sv */
// one cell of the payload byte chain, holds a byte and compares it
module tppf_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic       vld_i,
  input  logic [7:0] pat_byte_i,
  output logic [7:0] byte_o,
  output logic       vld_o,
  output logic       eq_o
);
  logic [7:0] byte_q;
  logic       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;
  assign eq_o   = vld_q && (byte_q == pat_byte_i);
endmodule

/* test/tppf_checker.sv */
// verdict predictor and checker for the tcp payload pattern filter testbench
`timescale 1ns / 100ps

module tppf_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tppf_in_if   in_i,
  tppf_out_if  out_i,
  tppf_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  import tppf_pkg::*;

  typedef struct packed {
    logic    drop;
    reason_e reason;
  } verdict_t;

  logic [7:0]  proto_cfg;
  logic [15:0] port_cfg;
  logic [31:0] pattern_cfg;

  logic [15:0] byte_pos;
  logic [5:0]  ip_hlen;
  logic [15:0] total_len;
  logic [7:0]  protocol_seen;
  logic [15:0] dest_port;
  logic [5:0]  tcp_hlen;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_cnt;
  logic        found;
  logic        stopped;

  verdict_t verdicts[$];
  verdict_t next_v;
  verdict_t want_v;
  int       fails = 0;
  int       pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void clear_packet_state();
    byte_pos      = '0;
    ip_hlen       = '0;
    total_len     = '0;
    protocol_seen = '0;
    dest_port     = '0;
    tcp_hlen      = '0;
    tail_bytes    = '0;
    tail_cnt      = '0;
    found         = 1'b0;
    stopped       = 1'b0;
  endfunction

  // advances the packet parser by one byte, returns 1 when a verdict is due
  function automatic bit filter_step(input logic [7:0] b, input logic lst,
                                     output verdict_t v);
    int unsigned idx;
    int unsigned th;
    int unsigned start;
    idx = byte_pos;
    th  = ip_hlen;
    v   = '0;
    if (idx == 0) ip_hlen = {b[3:0], 2'b00};
    if (idx == 2) total_len[15:8] = b;
    if (idx == 3) total_len[7:0] = b;
    if (idx == 9) protocol_seen = b;
    if (idx != 0) begin
      if (idx == th + 2) dest_port[15:8] = b;
      if (idx == th + 3) dest_port[7:0] = b;
      if (idx == th + 12) tcp_hlen = {b[7:4], 2'b00};
      start = th + ((tcp_hlen > 13) ? tcp_hlen : 13);
      if (!stopped && idx >= start && idx < total_len) begin
        // zero byte ends the scan like a string terminator
        if (b == 8'h00) begin
          stopped = 1'b1;
        end else begin
          if (tail_cnt == 2'd3 && {tail_bytes, b} == pattern_cfg) found = 1'b1;
          tail_bytes = {tail_bytes[15:0], b};
          if (tail_cnt < 2'd3) tail_cnt = tail_cnt + 2'd1;
        end
      end
    end
    if (!lst) begin
      if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;
      return 1'b0;
    end
    th = ip_hlen;
    v.drop = 1'b0;
    if (idx < 9) begin
      v.reason = REASON_TRUNCATED;
    end else if (protocol_seen != proto_cfg) begin
      v.reason = REASON_PROTOCOL;
    end else if (idx < th + 3) begin
      v.reason = REASON_TRUNCATED;
    end else if (dest_port != port_cfg) begin
      v.reason = REASON_PORT;
    end else if (idx < th + 12) begin
      v.reason = REASON_TRUNCATED;
    end else if (found) begin
      v.reason = REASON_FOUND;
      v.drop   = 1'b1;
    end else begin
      v.reason = REASON_CLEAN;
    end
    clear_packet_state();
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_cfg   = ProtoReset;
      port_cfg    = PortReset;
      pattern_cfg = PatternReset;
      clear_packet_state();
      verdicts.delete();
      pending = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_PROTOCOL: proto_cfg = cfg_i.data[7:0];
          CFG_PORT:     port_cfg = cfg_i.data[15:0];
          CFG_PATTERN:  pattern_cfg = cfg_i.data;
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (verdicts.size() == 0) begin
          fails++;
          $display("%0t: unexpected verdict, expected none, actual drop %0b reason %0d",
                   $time, out_i.drop, out_i.reason);
        end else begin
          want_v = verdicts.pop_front();
          if (out_i.drop !== want_v.drop) begin
            fails++;
            $display("%0t: drop mismatch, expected %0b, actual %0b",
                     $time, want_v.drop, out_i.drop);
          end
          if (out_i.reason !== want_v.reason) begin
            fails++;
            $display("%0t: reason mismatch, expected %0d, actual %0d",
                     $time, want_v.reason, out_i.reason);
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (filter_step(in_i.data_byte, in_i.last_byte, next_v)) verdicts.push_back(next_v);
      end
      pending = verdicts.size();
    end
  end

endmodule

/* test/tb_top.sv */
// stimulus and final verdict for the tcp payload pattern filter testbench
`timescale 1ns / 100ps

module tb_top;
  import tppf_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int HoldCycles    = 400;
  localparam int RandomBytes   = 480;
  localparam int NumPhases     = 6;
  localparam int QuietPhase    = 2;
  localparam int PressurePhase = 3;
  localparam logic [7:0] ProtoUdp = 8'd17;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   hold_req;
  bit   quiet;
  int   bytes_sent;

  logic [7:0]  cur_proto;
  logic [15:0] cur_port;
  logic [31:0] cur_pattern;
  logic [7:0]  pkt[$];

  tppf_in_if  in_if ();
  tppf_out_if out_if ();
  tppf_cfg_if cfg_if ();

  tcp_payload_pattern_filter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  tppf_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result sink with random stalls and one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic lst);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) >= 65) gap = idle_len();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = d;
    in_if.last_byte = lst;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] proto, input logic [15:0] port,
                               input logic [31:0] pattern);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    // unused upper bits carry noise
    write_reg(CFG_PROTOCOL, {24'($urandom), proto});
    write_reg(CFG_PORT, {16'($urandom), port});
    write_reg(CFG_PATTERN, pattern);
    cur_proto   = proto;
    cur_port    = port;
    cur_pattern = pattern;
  endtask

  function automatic logic [7:0] payload_byte();
    int k;
    if ($urandom_range(0, 99) < 40) begin
      k = $urandom_range(0, 3);
      return cur_pattern[31 - 8 * k -: 8];
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // builds an ipv4/tcp byte stream; header fields are written last so they win overlaps
  task automatic make_packet(input int ihl, input int doff, input int pay_len,
                             input logic [7:0] proto, input logic [15:0] port,
                             input int len_adj, input int pat_at, input int zero_at,
                             input int cut);
    int th;
    int start;
    int n;
    int tot;
    th    = ihl * 4;
    start = th + ((doff * 4 > 13) ? doff * 4 : 13);
    n     = start + pay_len;
    pkt.delete();
    for (int i = 0; i < n; i++) begin
      if (i < start) pkt.push_back(8'($urandom));
      else pkt.push_back(payload_byte());
    end
    if (pat_at >= 0 && pat_at + 4 <= pay_len) begin
      for (int k = 0; k < 4; k++) pkt[start + pat_at + k] = cur_pattern[31 - 8 * k -: 8];
    end
    if (zero_at >= 0 && zero_at < pay_len) pkt[start + zero_at] = 8'h00;
    pkt[th + 2]  = port[15:8];
    pkt[th + 3]  = port[7:0];
    pkt[th + 12] = {4'(doff), 4'($urandom)};
    pkt[9]       = proto;
    pkt[0]       = {4'h4, 4'(ihl)};
    tot = n + len_adj;
    if (tot < 0) tot = 0;
    if (tot > 65535) tot = 65535;
    pkt[2] = 8'(tot >> 8);
    pkt[3] = 8'(tot);
    if (cut > 0) begin
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic random_packet();
    int ihl;
    int doff;
    int pay_len;
    int len_adj;
    int pat_at;
    int zero_at;
    int cut;
    int n;
    logic [7:0]  proto;
    logic [15:0] port;
    if ($urandom_range(0, 99) < 5) begin
      n = $urandom_range(1, 40);
      pkt.delete();
      repeat (n) pkt.push_back(8'($urandom));
      return;
    end
    ihl     = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(0, 15);
    doff    = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(0, 15);
    pay_len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 30) : $urandom_range(31, 60);
    proto   = ($urandom_range(0, 99) < 85) ? cur_proto : 8'($urandom);
    port    = ($urandom_range(0, 99) < 80) ? cur_port : 16'($urandom);
    len_adj = 0;
    if ($urandom_range(0, 99) < 25) len_adj = $urandom_range(0, 40) - 20;
    if ($urandom_range(0, 99) < 3) len_adj = 65535;
    pat_at  = -1;
    if (pay_len >= 4 && $urandom_range(0, 1) == 1) pat_at = $urandom_range(0, pay_len - 4);
    zero_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 30) : -1;
    cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
    make_packet(ihl, doff, pay_len, proto, port, len_adj, pat_at, zero_at, cut);
  endtask

  initial begin : stimulus
    int target;
    logic [31:0] pat;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    quiet           = 1'b0;
    bytes_sent      = 0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_PROTOCOL;
    cfg_if.data     = 32'h0;
    cur_proto       = ProtoReset;
    cur_port        = PortReset;
    cur_pattern     = PatternReset;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed packets under reset settings
    make_packet(5, 5, 20, cur_proto, cur_port, 0, 3, -1, 0);
    send_packet();
    make_packet(5, 5, 12, cur_proto, cur_port, 0, -1, -1, 0);
    send_packet();
    make_packet(5, 5, 10, ProtoUdp, cur_port, 0, 2, -1, 0);
    send_packet();
    make_packet(5, 5, 10, cur_proto, 16'd80, 0, 2, -1, 0);
    send_packet();
    // truncated before protocol, single byte, before port, before data offset
    make_packet(5, 5, 10, cur_proto, cur_port, 0, 2, -1, 5);
    send_packet();
    make_packet(5, 5, 10, cur_proto, cur_port, 0, 2, -1, 1);
    send_packet();
    make_packet(5, 5, 10, cur_proto, cur_port, 0, 2, -1, 23);
    send_packet();
    make_packet(5, 5, 10, cur_proto, cur_port, 0, 2, -1, 30);
    send_packet();
    // zero byte ahead of the pattern stops the scan
    make_packet(5, 5, 20, cur_proto, cur_port, 0, 5, 1, 0);
    send_packet();
    // pattern beyond total length
    make_packet(5, 5, 20, cur_proto, cur_port, -8, 14, -1, 0);
    send_packet();
    // small ihl and small data offset, then the largest of both with total length 65535
    make_packet(0, 5, 16, cur_proto, cur_port, 0, 4, -1, 0);
    send_packet();
    make_packet(2, 5, 16, cur_proto, cur_port, 0, 4, -1, 0);
    send_packet();
    make_packet(5, 0, 16, cur_proto, cur_port, 0, 0, -1, 0);
    send_packet();
    make_packet(15, 15, 8, cur_proto, cur_port, 65535, 4, -1, 0);
    send_packet();
    // pattern holding a zero byte never matches; then all-ones settings, then protocol 0 and port 0
    apply_setting(ProtoReset, PortReset, 32'h0065_7865);
    make_packet(5, 5, 16, cur_proto, cur_port, 0, 4, -1, 0);
    send_packet();
    apply_setting(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    make_packet(5, 5, 16, cur_proto, cur_port, 0, 4, -1, 0);
    send_packet();
    apply_setting(8'h00, 16'h0000, 32'h0102_0304);
    make_packet(5, 5, 16, cur_proto, cur_port, 0, 4, -1, 0);
    send_packet();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        apply_setting(ProtoReset, PortReset, PatternReset);
      end else if (p == QuietPhase) begin
        apply_setting(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      end else if (p == PressurePhase) begin
        apply_setting(8'h00, 16'h0000, 32'h0102_0304);
      end else begin
        pat = 32'($urandom);
        if (p != NumPhases - 2) begin
          for (int k = 0; k < 4; k++) begin
            if (pat[8 * k +: 8] == 8'h00) pat[8 * k +: 8] = 8'h5A;
          end
        end
        apply_setting(8'($urandom), 16'($urandom), pat);
      end
      quiet  = (p == QuietPhase);
      target = bytes_sent + RandomBytes / NumPhases;
      if (p == PressurePhase) begin
        hold_req = 1'b1;
        repeat (30) begin
          make_packet(5, 5, 0, cur_proto, cur_port, 0, -1, -1, $urandom_range(9, 14));
          send_packet();
        end
      end
      while (bytes_sent < target) begin
        random_packet();
        send_packet();
      end
    end
    quiet = 1'b0;

    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tppf_pkg.sv
sv/tppf_if.sv
sv/tppf_hdr.sv
sv/tppf_cell.sv
sv/tcp_payload_pattern_filter.sv
test/tppf_checker.sv
test/tb_top.sv
